// ----- hdl/sfsd_pkg.sv -----
// ============================================================================
// sfsd_pkg
// Shared constants for the sensor frame spike detector.
// ============================================================================
package sfsd_pkg;

    // Defaults of the design parameters.
    localparam int SENSORS_PER_PORT_DEF = 8;
    localparam int HISTORY_DEPTH_DEF    = 8;
    localparam int TOTAL_SENSORS_DEF    = 16;

    // Field and register widths.
    localparam int BYTE_W   = 8;
    localparam int SAMPLE_W = 16;
    localparam int GAIN_W   = 8;
    localparam int MASK_W   = 8;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 1;
    localparam int COUNT_W  = 6;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 6'd63;

    // Frame header bytes.
    localparam logic [BYTE_W-1:0] HDR_A = 8'hff;
    localparam logic [BYTE_W-1:0] HDR_B = 8'h06;
    localparam logic [BYTE_W-1:0] HDR_C = 8'h09;

    // Configuration register indexes and reset values.
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_GAIN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_AVERAGE    = 1'd1;
    localparam logic [GAIN_W-1:0]    GAIN_RESET         = 8'd32;
    localparam logic [SAMPLE_W-1:0]  MIN_AVG_RESET      = 16'd1000;

endpackage

// ----- hdl/sfsd_ram.sv -----
// ============================================================================
// sfsd_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ============================================================================
module sfsd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ----- hdl/sfsd_div.sv -----
// ============================================================================
// sfsd_div
// Divider by a constant: reciprocal multiplication, quotient registered in the cycle
// after start.
// ============================================================================
module sfsd_div #(
    parameter int NUM_W   = 19,
    parameter int DIVISOR = 8
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [NUM_W-1:0]            numer,
    output logic                        done,
    output logic [sfsd_pkg::SAMPLE_W-1:0] quot
);
    import sfsd_pkg::*;

    // The scale gives an exact floor for every NUM_W-bit numerator.
    localparam int              LOG_D   = $clog2(DIVISOR);
    localparam int              SHIFT   = NUM_W + LOG_D;
    localparam longint unsigned RECIP   = ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) /
                                          64'(DIVISOR);
    localparam int              RECIP_W = $clog2(RECIP + 1);
    localparam int              PROD_W  = NUM_W + RECIP_W;

    logic [PROD_W-1:0] prod_reg, prod_next;
    logic              done_reg, done_next;
    logic [PROD_W-1:0] shifted;

    always_comb begin
        prod_next = prod_reg;
        done_next = start;
        if (start) begin
            prod_next = PROD_W'(numer) * PROD_W'(RECIP);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= done_next;
        end
        prod_reg <= prod_next;
    end

    assign shifted = prod_reg >> SHIFT;
    assign done    = done_reg;
    // The average fits in the sample width; upper bits are dropped.
    assign quot    = shifted[SAMPLE_W-1:0];
endmodule

// ----- hdl/sensor_frame_spike_detector.sv -----
// ============================================================================
// sensor_frame_spike_detector
// Checks framed sensor chunks and flags samples above gain/16 times their moving average
// (if it is at least the minimum), keeping a history ring and running sums in RAM.
// ============================================================================
//  channel   ports                                   role
//  s_        s_port, s_data_byte, s_chunk_end        received bytes in
//  m_        m_accepted, m_from_port, m_trigger_mask one result per chunk
//  cfg_      cfg_we, cfg_index, cfg_data             register writes
//
// A byte is taken only in the idle state. A chunk end that is rejected gives its result
// the next cycle. An accepted frame walks the port's sensors; each sensor passes
// five steps (read, load, average, multiply, write back; a sensor past TOTAL_SENSORS
// ends at the read), and the result item is loaded at the end of the walk.
// After reset the history ring and sums are cleared, one entry per cycle over all
// HISTORY_DEPTH * TOTAL_SENSORS ring entries, while no byte is taken.
// A waiting result stalls only a chunk end and the end of a commit walk.
module sensor_frame_spike_detector #(
    parameter int SENSORS_PER_PORT = sfsd_pkg::SENSORS_PER_PORT_DEF,
    parameter int HISTORY_DEPTH    = sfsd_pkg::HISTORY_DEPTH_DEF,
    parameter int TOTAL_SENSORS    = sfsd_pkg::TOTAL_SENSORS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_port,
    input  logic [sfsd_pkg::BYTE_W-1:0]    s_data_byte,
    input  logic                           s_chunk_end,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_accepted,
    output logic                           m_from_port,
    output logic [sfsd_pkg::MASK_W-1:0]    m_trigger_mask,
    input  logic                           cfg_we,
    input  logic [sfsd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sfsd_pkg::CFG_W-1:0]     cfg_data
);
    import sfsd_pkg::*;

    localparam int FRAME_BYTES = 2 * SENSORS_PER_PORT + 4;
    localparam int RING_DEPTH  = HISTORY_DEPTH * TOTAL_SENSORS;
    localparam int RING_AW     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int SUM_AW      = (TOTAL_SENSORS > 1) ? $clog2(TOTAL_SENSORS) : 1;
    localparam int HELD_AW     = (SENSORS_PER_PORT > 1) ? $clog2(SENSORS_PER_PORT) : 1;
    localparam int ROW_W       = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int SIDX_BASE_W = $clog2(2 * SENSORS_PER_PORT) + 1;
    localparam int SIDX_W      = (SIDX_BASE_W > SUM_AW) ? SIDX_BASE_W : SUM_AW;
    localparam int SUM_W       = SAMPLE_W + ((HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 0);
    localparam int PROD_W      = SAMPLE_W + GAIN_W;

    typedef enum logic [7:0] {
        ST_CLEAR = 8'b0000_0001,
        ST_IDLE  = 8'b0000_0010,
        ST_READ  = 8'b0000_0100,
        ST_LOAD  = 8'b0000_1000,
        ST_DIV   = 8'b0001_0000,
        ST_MUL   = 8'b0010_0000,
        ST_WRITE = 8'b0100_0000,
        ST_FIN   = 8'b1000_0000
    } state_t;

    state_t st_reg, st_next;

    logic [GAIN_W-1:0]   gain_reg;
    logic [SAMPLE_W-1:0] min_reg;

    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic               hdr_reg, hdr_next;
    logic [BYTE_W-1:0]  hi_reg, hi_next;
    logic [RING_AW-1:0] clr_reg, clr_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [HELD_AW-1:0] idx_reg, idx_next;
    logic               port_reg, port_next;
    logic [MASK_W-1:0]  mask_reg, mask_next;

    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [SAMPLE_W-1:0] old_reg, old_next;
    logic [SAMPLE_W-1:0] smp_reg, smp_next;
    logic [SAMPLE_W-1:0] avg_reg, avg_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;

    logic               mv_reg, mv_next;
    logic               macc_reg, macc_next;
    logic               mport_reg, mport_next;
    logic [MASK_W-1:0]  mmask_reg, mmask_next;

    // RAM ports
    logic                ring_we, sums_we, held_we;
    logic [RING_AW-1:0]  ring_waddr, ring_raddr;
    logic [SAMPLE_W-1:0] ring_wdata, ring_rdata;
    logic [SUM_AW-1:0]   sums_waddr, sums_raddr;
    logic [SUM_W-1:0]    sums_wdata, sums_rdata;
    logic [HELD_AW-1:0]  held_waddr;
    logic [SAMPLE_W-1:0] held_wdata, held_rdata;

    logic                div_start, div_done;
    logic [SAMPLE_W-1:0] div_quot;

    logic               in_fire, out_free;
    logic [SIDX_W-1:0]  sidx;
    logic               s_out;
    logic [RING_AW-1:0] ring_addr;
    logic [COUNT_W-1:0] pos;
    logic [COUNT_W-1:0] rel;
    logic               len_ok;

    assign out_free = !mv_reg || m_ready;
    assign s_ready  = (st_reg == ST_IDLE) && (!s_chunk_end || out_free);
    assign in_fire  = s_valid && s_ready;

    assign sidx  = SIDX_W'(port_reg) * SIDX_W'(SENSORS_PER_PORT) + SIDX_W'(idx_reg);
    assign s_out = (sidx >= SIDX_W'(TOTAL_SENSORS));
    assign ring_addr = RING_AW'(row_reg) * RING_AW'(TOTAL_SENSORS) + RING_AW'(sidx);
    assign pos = cnt_reg;
    assign rel = pos - COUNT_W'(4);

    assign ring_raddr = ring_addr;
    assign sums_raddr = sidx[SUM_AW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg <= GAIN_RESET;
            min_reg  <= MIN_AVG_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_THRESHOLD_GAIN: gain_reg <= cfg_data[GAIN_W-1:0];
                CFG_MIN_AVERAGE:    min_reg  <= cfg_data[SAMPLE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        st_next    = st_reg;
        cnt_next   = cnt_reg;
        hdr_next   = hdr_reg;
        hi_next    = hi_reg;
        clr_next   = clr_reg;
        row_next   = row_reg;
        idx_next   = idx_reg;
        port_next  = port_reg;
        mask_next  = mask_reg;
        sum_next   = sum_reg;
        old_next   = old_reg;
        smp_next   = smp_reg;
        avg_next   = avg_reg;
        prod_next  = prod_reg;
        mv_next    = mv_reg && !m_ready;
        macc_next  = macc_reg;
        mport_next = mport_reg;
        mmask_next = mmask_reg;
        ring_we    = 1'b0;
        ring_waddr = ring_addr;
        ring_wdata = smp_reg;
        sums_we    = 1'b0;
        sums_waddr = sidx[SUM_AW-1:0];
        sums_wdata = SUM_W'(sum_reg - SUM_W'(old_reg) + SUM_W'(smp_reg));
        held_we    = 1'b0;
        held_waddr = rel[HELD_AW:1];
        held_wdata = {hi_reg, s_data_byte};
        div_start  = 1'b0;
        len_ok     = 1'b0;

        unique case (st_reg)
            ST_CLEAR: begin
                ring_we    = 1'b1;
                ring_waddr = clr_reg;
                ring_wdata = '0;
                sums_waddr = clr_reg[SUM_AW-1:0];
                sums_wdata = '0;
                sums_we    = ({1'b0, clr_reg} < (RING_AW + 1)'(TOTAL_SENSORS));
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == RING_AW'(RING_DEPTH - 1)) begin
                    st_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_fire) begin
                    priority if (pos == COUNT_W'(0) || pos == COUNT_W'(1)) begin
                        hdr_next = hdr_reg && (s_data_byte == HDR_A);
                    end else if (pos == COUNT_W'(2)) begin
                        hdr_next = hdr_reg && (s_data_byte == HDR_B);
                    end else if (pos == COUNT_W'(3)) begin
                        hdr_next = hdr_reg && (s_data_byte == HDR_C);
                    end else if (pos < COUNT_W'(FRAME_BYTES)) begin
                        // High byte waits in a register; the word is stored on the low byte.
                        if (!rel[0]) begin
                            hi_next = s_data_byte;
                        end else begin
                            held_we = 1'b1;
                        end
                    end
                    if (cnt_reg != COUNT_MAX) begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                    if (s_chunk_end) begin
                        len_ok = (cnt_next == COUNT_W'(FRAME_BYTES)) ||
                                 (cnt_next == COUNT_W'(2 * FRAME_BYTES));
                        cnt_next  = '0;
                        hdr_next  = 1'b1;
                        port_next = s_port;
                        if (hdr_reg && hdr_next && len_ok) begin
                            idx_next  = '0;
                            mask_next = '0;
                            st_next   = ST_READ;
                        end else begin
                            mv_next    = 1'b1;
                            macc_next  = 1'b0;
                            mport_next = s_port;
                            mmask_next = '0;
                        end
                    end
                end
            end
            ST_READ: begin
                if (s_out) begin
                    if (idx_reg == HELD_AW'(SENSORS_PER_PORT - 1)) begin
                        st_next = ST_FIN;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end else begin
                    st_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                sum_next  = sums_rdata;
                old_next  = ring_rdata;
                smp_next  = held_rdata;
                div_start = 1'b1;
                st_next   = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    avg_next = div_quot;
                    st_next  = ST_MUL;
                end
            end
            ST_MUL: begin
                prod_next = PROD_W'(avg_reg) * PROD_W'(gain_reg);
                st_next   = ST_WRITE;
            end
            ST_WRITE: begin
                if (avg_reg >= min_reg && PROD_W'({smp_reg, 4'b0000}) > prod_reg) begin
                    mask_next[idx_reg] = 1'b1;
                end
                ring_we = 1'b1;
                sums_we = 1'b1;
                if (idx_reg == HELD_AW'(SENSORS_PER_PORT - 1)) begin
                    st_next = ST_FIN;
                end else begin
                    idx_next = idx_reg + 1'b1;
                    st_next  = ST_READ;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    mv_next    = 1'b1;
                    macc_next  = 1'b1;
                    mport_next = port_reg;
                    mmask_next = mask_reg;
                    row_next   = (row_reg == ROW_W'(HISTORY_DEPTH - 1)) ? '0 : row_reg + 1'b1;
                    st_next    = ST_IDLE;
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= ST_CLEAR;
            cnt_reg  <= '0;
            hdr_reg  <= 1'b1;
            clr_reg  <= '0;
            row_reg  <= '0;
            idx_reg  <= '0;
            mv_reg   <= 1'b0;
        end else begin
            st_reg   <= st_next;
            cnt_reg  <= cnt_next;
            hdr_reg  <= hdr_next;
            clr_reg  <= clr_next;
            row_reg  <= row_next;
            idx_reg  <= idx_next;
            mv_reg   <= mv_next;
        end
        hi_reg    <= hi_next;
        port_reg  <= port_next;
        mask_reg  <= mask_next;
        sum_reg   <= sum_next;
        old_reg   <= old_next;
        smp_reg   <= smp_next;
        avg_reg   <= avg_next;
        prod_reg  <= prod_next;
        macc_reg  <= macc_next;
        mport_reg <= mport_next;
        mmask_reg <= mmask_next;
    end

    sfsd_ram #(.WIDTH(SAMPLE_W), .DEPTH(RING_DEPTH)) u_ring (
        .aclk  (aclk),
        .we    (ring_we),
        .waddr (ring_waddr),
        .wdata (ring_wdata),
        .raddr (ring_raddr),
        .rdata (ring_rdata)
    );

    sfsd_ram #(.WIDTH(SUM_W), .DEPTH(TOTAL_SENSORS)) u_sums (
        .aclk  (aclk),
        .we    (sums_we),
        .waddr (sums_waddr),
        .wdata (sums_wdata),
        .raddr (sums_raddr),
        .rdata (sums_rdata)
    );

    sfsd_ram #(.WIDTH(SAMPLE_W), .DEPTH(SENSORS_PER_PORT)) u_held (
        .aclk  (aclk),
        .we    (held_we),
        .waddr (held_waddr),
        .wdata (held_wdata),
        .raddr (idx_reg),
        .rdata (held_rdata)
    );

    sfsd_div #(.NUM_W(SUM_W), .DIVISOR(HISTORY_DEPTH)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .numer   (sums_rdata),
        .done    (div_done),
        .quot    (div_quot)
    );

    assign m_valid        = mv_reg;
    assign m_accepted     = macc_reg;
    assign m_from_port    = mport_reg;
    assign m_trigger_mask = mmask_reg;

    // No byte may be taken while the memories are cleared or a frame commits.
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (st_reg == ST_IDLE))
        else $error("input ready outside idle");

    // The ring row moves on exactly when a committed result is loaded.
    a_row_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_FIN && out_free) |=> (row_reg != $past(row_reg) || HISTORY_DEPTH == 1))
        else $error("ring row did not advance after a commit");

    // Sums are written only by the clearing pass or the write-back step.
    a_sum_write: assert property (@(posedge aclk) disable iff (!aresetn)
        sums_we |-> (st_reg == ST_CLEAR || st_reg == ST_WRITE))
        else $error("sums written outside clear or write-back");

    // A rejected chunk end is answered by a valid result marked not accepted.
    a_reject: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && s_chunk_end && st_next == ST_IDLE) |=> (m_valid && !m_accepted))
        else $error("rejected chunk without a result");
endmodule
